// File: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define RFH_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high
`define RFH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/rfh_pkg.sv
// Package: constants and types of the relay toggle frame handler
`timescale 1ns / 1ps
package rfh_pkg;

   localparam logic [7:0] OPEN_BYTE  = 8'hAA;
   localparam logic [7:0] CLOSE_BYTE = 8'hFF;
   localparam logic [7:0] NO_KEY     = 8'hFF;
   localparam logic [7:0] REPLY_HEAD = 8'h1A;
   localparam logic [7:0] REPLY_TAIL = 8'h3A;
   localparam int         NUM_RELAYS = 16;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // One reply command: relay snapshot after toggle and the offset
   typedef struct packed {
      logic [NUM_RELAYS-1:0] relays;
      logic [4:0]            offset;
   } cmd_type;

   // Queue status seen by the two sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      SLOT_HEAD,
      SLOT_OFFSET,
      SLOT_LOW,
      SLOT_HIGH,
      SLOT_TAIL
   } slot_type;

endpackage

// File: rtl/rfh_front.sv
// Front end: frame parsing, key decode and relay toggle
`timescale 1ns / 1ps
module rfh_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  logic [4:0]           req_random_offset,
   input  rfh_pkg::q_status_type q_status,
   output logic                 q_push,
   output rfh_pkg::cmd_type     q_entry
);

   logic                          frame_open_ff, frame_open_in;
   logic [1:0]                    count_ff, count_in;
   logic [7:0]                    pay0_ff, pay0_in, pay1_ff, pay1_in;
   logic [7:0]                    lat0_ff, lat0_in, lat1_ff, lat1_in;
   logic [rfh_pkg::NUM_RELAYS-1:0] relays_ff, relays_in;
   logic                          accept;
   logic [7:0]                    key;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      frame_open_in = frame_open_ff;
      count_in      = count_ff;
      pay0_in       = pay0_ff;
      pay1_in       = pay1_ff;
      lat0_in       = lat0_ff;
      lat1_in       = lat1_ff;
      relays_in     = relays_ff;
      key           = 8'd0;
      q_push        = 1'b0;
      q_entry       = '0;
      if (accept) begin
         priority if (req_rx_byte == rfh_pkg::OPEN_BYTE) begin
            frame_open_in = 1'b1;
            count_in      = 2'd0;
         end else if (req_rx_byte == rfh_pkg::CLOSE_BYTE) begin
            frame_open_in = 1'b0;
            // copy only the bytes stored so far; the rest of the latch holds
            if (count_ff >= 2'd1) lat0_in = pay0_ff;
            if (count_ff >= 2'd2) lat1_in = pay1_ff;
            key     = lat1_in - lat0_in;
            lat1_in = key;
            if (key != rfh_pkg::NO_KEY) begin
               if (key < 8'(rfh_pkg::NUM_RELAYS))
                  relays_in = relays_ff ^ (16'd1 << key[3:0]);
               q_push         = 1'b1;
               q_entry.relays = relays_in;
               q_entry.offset = req_random_offset;
            end
         end else if (frame_open_ff && count_ff < 2'd2) begin
            if (count_ff[0]) pay1_in = req_rx_byte;
            else             pay0_in = req_rx_byte;
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         count_ff      <= 2'd0;
         pay0_ff       <= 8'd0;
         pay1_ff       <= 8'd0;
         lat0_ff       <= 8'd0;
         lat1_ff       <= 8'd0;
         relays_ff     <= '0;
      end else begin
         frame_open_ff <= frame_open_in;
         count_ff      <= count_in;
         pay0_ff       <= pay0_in;
         pay1_ff       <= pay1_in;
         lat0_ff       <= lat0_in;
         lat1_ff       <= lat1_in;
         relays_ff     <= relays_in;
      end
   end

endmodule

// File: rtl/rfh_queue.sv
// Command queue between front end and reply sender
`timescale 1ns / 1ps
module rfh_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rfh_pkg::cmd_type      push_entry,
   input  logic                  pop,
   output rfh_pkg::cmd_type      head,
   output rfh_pkg::q_status_type status
);

   rfh_pkg::cmd_type             entry_ff [rfh_pkg::Q_DEPTH];
   logic [rfh_pkg::Q_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [rfh_pkg::Q_CNT_W-1:0]  count_ff;
   logic                         do_push, do_pop;

   assign status.full  = (count_ff == rfh_pkg::Q_CNT_W'(rfh_pkg::Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// File: rtl/rfh_back.sv
// Back end: emits the five-byte reply for each queued command
`timescale 1ns / 1ps
module rfh_back (
   input  logic                           clock,
   input  logic                           reset,
   input  rfh_pkg::cmd_type               head,
   input  rfh_pkg::q_status_type          q_status,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_tx_byte,
   output logic [rfh_pkg::NUM_RELAYS-1:0] rsp_relay_state,
   output logic                           rsp_last_byte
);

   rfh_pkg::slot_type              slot_ff, slot_in;
   logic                           valid_ff, valid_in;
   logic [7:0]                     tx_ff, tx_in;
   logic [rfh_pkg::NUM_RELAYS-1:0] relay_ff, relay_in;
   logic                           last_ff, last_in;
   logic                           load;
   logic [7:0]                     offset8;

   assign offset8 = {3'd0, head.offset};
   assign load    = !valid_ff || !rsp_stall;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      tx_in    = tx_ff;
      relay_in = relay_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            relay_in = head.relays;
            last_in  = 1'b0;
            unique case (slot_ff)
               rfh_pkg::SLOT_HEAD: begin
                  tx_in   = rfh_pkg::REPLY_HEAD;
                  slot_in = rfh_pkg::SLOT_OFFSET;
               end
               rfh_pkg::SLOT_OFFSET: begin
                  tx_in   = offset8;
                  slot_in = rfh_pkg::SLOT_LOW;
               end
               rfh_pkg::SLOT_LOW: begin
                  tx_in   = head.relays[7:0] + offset8;
                  slot_in = rfh_pkg::SLOT_HIGH;
               end
               rfh_pkg::SLOT_HIGH: begin
                  tx_in   = head.relays[15:8] + offset8;
                  slot_in = rfh_pkg::SLOT_TAIL;
               end
               rfh_pkg::SLOT_TAIL: begin
                  // final byte: release the command
                  tx_in   = rfh_pkg::REPLY_TAIL;
                  last_in = 1'b1;
                  slot_in = rfh_pkg::SLOT_HEAD;
                  q_pop   = 1'b1;
               end
               default: begin
                  tx_in   = rfh_pkg::REPLY_HEAD;
                  slot_in = rfh_pkg::SLOT_HEAD;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= rfh_pkg::SLOT_HEAD;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff    <= tx_in;
      relay_ff <= relay_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_tx_byte     = tx_ff;
   assign rsp_relay_state = relay_ff;
   assign rsp_last_byte   = last_ff;

endmodule

// File: rtl/relay_toggle_frame_handler.sv
// Top level: relay toggle frame handler
//
//  channel  direction  handshake          payload
//  req_     in         req_valid/stall    rx_byte[7:0], random_offset[4:0]
//  rsp_     out        rsp_valid/stall    tx_byte[7:0], relay_state[15:0], last_byte
//
// A byte is taken every cycle while req_stall is low; a closing byte with a reply
// queues one command, which the reply sender emits as five bytes, one per cycle
// while rsp_stall is low; this sets the sustained rate for closing bytes, and the
// two-entry queue absorbs bursts. Replies leave via the queue and output registers.
// reset is synchronous; it clears frame state, relays, queue and output valid.
// req_stall is high only while the queue is full; rsp_stall holds the output.
`timescale 1ns / 1ps
module relay_toggle_frame_handler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic [4:0]  req_random_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic [15:0] rsp_relay_state,
   output logic        rsp_last_byte
);

   rfh_pkg::q_status_type q_status;
   rfh_pkg::cmd_type      q_entry, q_head;
   logic                  q_push, q_pop;

   rfh_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_random_offset (req_random_offset),
      .q_status          (q_status),
      .q_push            (q_push),
      .q_entry           (q_entry)
   );

   rfh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   rfh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_relay_state (rsp_relay_state),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

// File: rtl/rfh_checker.sv
// Port-level checker for the relay toggle frame handler, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_tx_byte,
   input logic [15:0] rsp_relay_state,
   input logic        rsp_last_byte
);

   `RFH_ASSERT_NEXT(a_reset_clears_valid, clock, 1'b0, reset, !rsp_valid)
   `RFH_ASSERT_NEXT(a_reset_no_stall, clock, 1'b0, reset, !req_stall)
   `RFH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last_byte))
   `RFH_ASSERT_NOW(a_tail_byte, clock, reset, rsp_valid && rsp_last_byte, rsp_tx_byte == rfh_pkg::REPLY_TAIL)
   `RFH_ASSERT_NEXT(a_reply_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_last_byte, rsp_valid && rsp_relay_state == $past(rsp_relay_state))

endmodule

bind relay_toggle_frame_handler rfh_checker u_rfh_checker (.*);

// File: sim/relay_toggle_frame_handler_tb.sv
// Testbench: random and directed serial frames checked against a built-in frame decoder
`timescale 1ns / 1ps
module relay_toggle_frame_handler_tb;

   typedef struct {
      logic [7:0] rx;
      logic [4:0] offs;
   } rx_item_type;

   typedef struct {
      logic [7:0]  tx;
      logic [15:0] relays;
      logic        last;
   } reply_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic [4:0]  req_random_offset = 5'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic [15:0] rsp_relay_state;
   logic        rsp_last_byte;

   rx_item_type    pending_rx[$];
   reply_byte_type reply_q[$];

   // decoder state
   logic        rx_open = 1'b0;
   logic [1:0]  rx_cnt = 2'd0;
   logic [7:0]  rx_pay[2] = '{8'h00, 8'h00};
   logic [7:0]  latch[2] = '{8'h00, 8'h00};
   logic [15:0] relay_bits = 16'h0000;

   int total_items = 0;
   int sent_cnt = 0;
   int checked_cnt = 0;
   int reply_cnt = 0;
   int toggle_cnt = 0;
   int err_cnt = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   relay_toggle_frame_handler dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_random_offset (req_random_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_relay_state   (rsp_relay_state),
      .rsp_last_byte     (rsp_last_byte)
   );

   initial forever #2 clock = ~clock;

   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int send_idle_pct();
      if (sent_cnt < total_items / 3) return 34;
      else if (sent_cnt < 2 * total_items / 3) return 68;
      else return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (sent_cnt < total_items / 3) return 68;
      else if (sent_cnt < 2 * total_items / 3) return 34;
      else return 0;
   endfunction

   function automatic logic [4:0] pick_offset();
      // mostly the nominal 1..16, sometimes anything the port can carry
      if ($urandom_range(9) == 0) return 5'($urandom_range(31));
      return 5'($urandom_range(16, 1));
   endfunction

   task automatic queue_rx(input logic [7:0] b, input logic [4:0] r);
      rx_item_type it;
      it.rx = b;
      it.offs = r;
      pending_rx.push_back(it);
   endtask

   task automatic push_reply(input logic [7:0] b, input logic last);
      reply_byte_type rb;
      rb.tx = b;
      rb.relays = relay_bits;
      rb.last = last;
      reply_q.push_back(rb);
   endtask

   // Advance the frame decoder by one received byte and queue any reply
   task automatic decode_rx_byte(input logic [7:0] b, input logic [4:0] r);
      logic [7:0] key;
      logic [7:0] offs;
      offs = {3'b000, r};
      if (b == rfh_pkg::OPEN_BYTE) begin
         rx_open = 1'b1;
         rx_cnt = 2'd0;
      end else if (b != rfh_pkg::CLOSE_BYTE) begin
         if (rx_open && rx_cnt < 2'd2) begin
            rx_pay[rx_cnt[0]] = b;
            rx_cnt = rx_cnt + 2'd1;
         end
      end else begin
         // close acts even without an open frame; count is kept from the last one
         rx_open = 1'b0;
         for (int i = 0; i < 2; i++)
            if (i < rx_cnt) latch[i] = rx_pay[i];
         key = latch[1] - latch[0];
         latch[1] = key;
         if (key != rfh_pkg::NO_KEY) begin
            if (key < rfh_pkg::NUM_RELAYS) begin
               relay_bits = relay_bits ^ (16'h0001 << key);
               toggle_cnt++;
            end
            push_reply(rfh_pkg::REPLY_HEAD, 1'b0);
            push_reply(offs, 1'b0);
            push_reply(relay_bits[7:0] + offs, 1'b0);
            push_reply(relay_bits[15:8] + offs, 1'b0);
            push_reply(rfh_pkg::REPLY_TAIL, 1'b1);
            reply_cnt++;
         end
      end
   endtask

   // Sender: present pending bytes, hold each one until the transfer happens
   always @(posedge clock) begin : drive_proc
      rx_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_rx_byte(req_rx_byte, req_random_offset);
            sent_cnt++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_rx.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
               nxt = pending_rx.pop_front();
               req_valid <= 1'b1;
               req_rx_byte <= nxt.rx;
               req_random_offset <= nxt.offs;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each reply byte and drive the stall
   always @(posedge clock) begin : check_proc
      reply_byte_type exp_b;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reply_q.size() == 0) begin
               $display("%0t: reply byte expected none, actual tx %h relays %h last %b",
                        $time, rsp_tx_byte, rsp_relay_state, rsp_last_byte);
               err_cnt++;
            end else begin
               exp_b = reply_q.pop_front();
               checked_cnt++;
               if (rsp_tx_byte !== exp_b.tx) begin
                  $display("%0t: tx_byte expected %h actual %h", $time, exp_b.tx, rsp_tx_byte);
                  err_cnt++;
               end
               if (rsp_relay_state !== exp_b.relays) begin
                  $display("%0t: relay_state expected %h actual %h",
                           $time, exp_b.relays, rsp_relay_state);
                  err_cnt++;
               end
               if (rsp_last_byte !== exp_b.last) begin
                  $display("%0t: last_byte expected %b actual %b",
                           $time, exp_b.last, rsp_last_byte);
                  err_cnt++;
               end
            end
         end
         // long hold-off once, so the reply queue fills and the input backs up
         if (!hold_done && sent_cnt >= 2 * total_items / 3 + 5) begin
            hold_left = 80;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct());
         end
      end
   end

   initial begin : stimulus
      int         sel;
      logic [7:0] key8;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] nb;

      // byte outside any frame, then close with nothing open
      queue_rx(8'h00, 5'd3);
      queue_rx(rfh_pkg::CLOSE_BYTE, 5'd0);
      // top relay toggles, widest offset
      queue_rx(rfh_pkg::OPEN_BYTE, 5'd1);
      queue_rx(8'h00, 5'd2);
      queue_rx(8'h0F, 5'd4);
      queue_rx(rfh_pkg::CLOSE_BYTE, 5'd31);
      // key of 255: no reply
      queue_rx(rfh_pkg::OPEN_BYTE, 5'd8);
      queue_rx(8'h10, 5'd16);
      queue_rx(8'h0F, 5'd1);
      queue_rx(rfh_pkg::CLOSE_BYTE, 5'd16);
      // payload overflow, key above the relay range still replies
      queue_rx(rfh_pkg::OPEN_BYTE, 5'd5);
      queue_rx(8'h01, 5'd10);
      queue_rx(8'h81, 5'd21);
      queue_rx(8'h55, 5'd26);
      queue_rx(rfh_pkg::CLOSE_BYTE, 5'd16);
      // short payload keeps the written-back key in the latch
      queue_rx(rfh_pkg::OPEN_BYTE, 5'd7);
      queue_rx(8'h05, 5'd11);
      queue_rx(rfh_pkg::CLOSE_BYTE, 5'd1);
      // close again without open: count from the previous frame
      queue_rx(rfh_pkg::CLOSE_BYTE, 5'd12);
      // empty frame
      queue_rx(rfh_pkg::OPEN_BYTE, 5'd15);
      queue_rx(rfh_pkg::CLOSE_BYTE, 5'd9);

      while (pending_rx.size() < 200) begin
         if ($urandom_range(9) < 7) begin
            sel = $urandom_range(9);
            if (sel < 5) key8 = 8'($urandom_range(15));
            else if (sel < 7) key8 = rfh_pkg::NO_KEY;
            else key8 = 8'($urandom_range(254, 16));
            b0 = 8'($urandom);
            b1 = b0 + key8;
            while (b0 == rfh_pkg::OPEN_BYTE || b0 == rfh_pkg::CLOSE_BYTE ||
                   b1 == rfh_pkg::OPEN_BYTE || b1 == rfh_pkg::CLOSE_BYTE)
            begin
               b0 = 8'($urandom);
               b1 = b0 + key8;
            end
            queue_rx(rfh_pkg::OPEN_BYTE, pick_offset());
            queue_rx(b0, pick_offset());
            queue_rx(b1, pick_offset());
            if ($urandom_range(4) == 0) queue_rx(8'($urandom), pick_offset());
            queue_rx(rfh_pkg::CLOSE_BYTE, pick_offset());
         end else begin
            // noise and broken frames
            repeat ($urandom_range(4, 1)) begin
               sel = $urandom_range(3);
               if (sel == 0) nb = rfh_pkg::OPEN_BYTE;
               else if (sel == 1) nb = rfh_pkg::CLOSE_BYTE;
               else nb = 8'($urandom);
               queue_rx(nb, pick_offset());
            end
         end
      end
      total_items = pending_rx.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (sent_cnt < total_items) @(posedge clock);
      while (reply_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d serial bytes, producing %0d replies and %0d relay toggles",
               total_items, reply_cnt, toggle_cnt);
      $display("Checked %0d reply bytes under sender and receiver stalls", checked_cnt);
      if (err_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
